>>> hdl/cme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cme_pkg
// Shared types, constants and register indexes of the CAN motor emulator.
// ----------------------------------------------------------------------------
package cme_pkg;

    localparam int BUS0_MOTORS = 6;
    localparam int BUS1_MOTORS = 3;
    localparam int NMOT        = BUS0_MOTORS + BUS1_MOTORS;
    localparam int ADDR_W      = $clog2(NMOT);

    localparam logic [10:0] BUS0_FIRST_ID = 11'h201;
    localparam logic [10:0] BUS1_FIRST_ID = 11'h205;
    localparam logic [10:0] FID_LOW       = 11'h200;
    localparam logic [10:0] FID_MID       = 11'h1FF;
    localparam logic [10:0] FID_HIGH      = 11'h2FF;

    // divider operand widths
    localparam int DVD_W = 33;
    localparam int DVS_W = 17;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HZ      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POS = 3'd4;

    typedef struct packed {
        logic        kind;
        logic        bus;
        logic [10:0] frame_id;
        logic [3:0]  length;
        logic [63:0] payload;
    } in_item_t;

    typedef struct packed {
        logic               out_bus;
        logic [10:0]        motor_id;
        logic signed [15:0] motor_position;
        logic signed [15:0] motor_rpm;
        logic signed [15:0] motor_acc;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic               control_mode;
        logic [9:0]         update_hz;
        logic [14:0]        max_rpm;
        logic signed [15:0] max_pos;
        logic signed [15:0] min_pos;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] pos;
        logic signed [15:0] rpm;
        logic signed [15:0] acc;
    } motor_rec_t;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        motor_rec_t        wdata;
    } mem_req_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

>>> hdl/cme_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cme_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cme_div (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cme_pkg::div_req_t req,
    output cme_pkg::div_rsp_t     rsp
);
    localparam int CNT_W = $clog2(cme_pkg::DVD_W + 1);

    logic [cme_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [cme_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [cme_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [cme_pkg::DVS_W:0]   shifted;
    logic [cme_pkg::DVS_W+1:0] diff;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[cme_pkg::DVD_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(cme_pkg::DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[cme_pkg::DVS_W+1]) begin
                rem_next = diff[cme_pkg::DVS_W-1:0];
                quo_next = {quo_reg[cme_pkg::DVD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[cme_pkg::DVS_W-1:0];
                quo_next = {quo_reg[cme_pkg::DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

>>> hdl/cme_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cme_mem
// Motor state memory: position, rpm and acceleration per motor, with a
// registered read. Entries not yet written read as zero.
// ----------------------------------------------------------------------------
module cme_mem (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cme_pkg::mem_req_t req,
    output cme_pkg::motor_rec_t    rdata
);
    cme_pkg::motor_rec_t         mem [cme_pkg::NMOT];
    logic [cme_pkg::NMOT-1:0]    vld_reg;
    cme_pkg::motor_rec_t         rd_reg;
    logic                        rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (req.wr) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd) begin
            rd_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.wr) begin
                vld_reg[req.addr] <= 1'b1;
            end
            if (req.rd) begin
                rd_vld_reg <= vld_reg[req.addr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule
`default_nettype wire

>>> hdl/cme_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cme_ctrl
// Sequencer: applies control frames to the motor memory and runs the tick
// integration per motor through the shared divider.
// ----------------------------------------------------------------------------
module cme_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cme_pkg::in_item_t   in_item,
    input  wire cme_pkg::cfg_t       cfg,
    input  wire logic                out_free,
    output logic                     out_load,
    output cme_pkg::out_item_t       out_item,
    output cme_pkg::mem_req_t        mem_req,
    input  wire cme_pkg::motor_rec_t mem_rdata,
    output cme_pkg::div_req_t        div_req,
    input  wire cme_pkg::div_rsp_t   div_rsp
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FRD   = 4'd1;
    localparam logic [3:0] S_FWR   = 4'd2;
    localparam logic [3:0] S_TRD   = 4'd3;
    localparam logic [3:0] S_TLAT  = 4'd4;
    localparam logic [3:0] S_TNUM1 = 4'd5;
    localparam logic [3:0] S_D1S   = 4'd6;
    localparam logic [3:0] S_D1W   = 4'd7;
    localparam logic [3:0] S_TPROD = 4'd8;
    localparam logic [3:0] S_TNUM2 = 4'd9;
    localparam logic [3:0] S_D2S   = 4'd10;
    localparam logic [3:0] S_D2W   = 4'd11;
    localparam logic [3:0] S_WRAP  = 4'd12;
    localparam logic [3:0] S_D3W   = 4'd13;
    localparam logic [3:0] S_TOUT  = 4'd14;

    logic [3:0]                  state_reg, state_next;
    logic [63:0]                 pay_reg, pay_next;
    logic [2:0]                  wcnt_reg, wcnt_next;
    logic signed [4:0]           j_reg, j_next;
    logic                        bus_reg, bus_next;
    logic [cme_pkg::ADDR_W-1:0]  k_reg, k_next;
    cme_pkg::motor_rec_t         rec_reg, rec_next;
    logic signed [27:0]          num1_reg, num1_next;
    logic [16:0]                 den_reg, den_next;
    logic signed [15:0]          nr_reg, nr_next;
    logic signed [33:0]          prod_reg, prod_next;
    logic signed [33:0]          num2_reg, num2_next;
    logic signed [26:0]          q2_reg, q2_next;
    logic                        lo_reg, lo_next;
    logic signed [15:0]          np_reg, np_next;

    logic [9:0]          hz_eff;
    logic signed [4:0]   j_base;
    logic                fid_ok;
    logic [2:0]          words;
    logic                j_ok;
    logic [cme_pkg::ADDR_W-1:0] j_addr;
    logic signed [15:0]  word;
    logic signed [16:0]  rsum;
    logic signed [16:0]  span;
    logic signed [27:0]  q2x;
    logic signed [27:0]  lo_gap;
    logic signed [27:0]  hi_gap;
    logic signed [16:0]  r17;
    logic signed [16:0]  wrapped;
    logic signed [27:0]  q1s;

    function automatic logic signed [15:0] clamp_rpm(input logic signed [27:0] v,
                                                     input logic [14:0] maxr);
        logic signed [27:0] m;
        m = $signed({13'd0, maxr});
        if (v < -m) begin
            clamp_rpm = 16'(-m);
        end else if (v > m) begin
            clamp_rpm = 16'(m);
        end else begin
            clamp_rpm = v[15:0];
        end
    endfunction

    always_comb begin
        hz_eff = (cfg.update_hz == 10'd0) ? 10'd1 : cfg.update_hz;
        fid_ok = 1'b1;
        j_base = 5'sd0;
        unique case (in_item.frame_id)
            cme_pkg::FID_LOW:  j_base = in_item.bus ? -5'sd4 : 5'sd0;
            cme_pkg::FID_MID:  j_base = in_item.bus ? 5'sd0 : 5'sd4;
            cme_pkg::FID_HIGH: j_base = in_item.bus ? 5'sd4 : 5'sd8;
            default:           fid_ok = 1'b0;
        endcase
        words = (in_item.length > 4'd8) ? 3'd4 : in_item.length[3:1];
        j_ok  = (j_reg >= 5'sd0) && (bus_reg ? (j_reg < 5'(cme_pkg::BUS1_MOTORS))
                                             : (j_reg < 5'(cme_pkg::BUS0_MOTORS)));
        j_addr = bus_reg ? cme_pkg::ADDR_W'(j_reg + 5'(cme_pkg::BUS0_MOTORS))
                         : cme_pkg::ADDR_W'(j_reg);
        word    = pay_reg[63:48];
        rsum    = 17'(nr_reg) + 17'(rec_reg.rpm);
        span    = 17'(cfg.max_pos) - 17'(cfg.min_pos);
        q2x     = 28'(q2_reg);
        lo_gap  = 28'(cfg.min_pos) - q2x;
        hi_gap  = q2x - 28'(cfg.max_pos);
        r17     = $signed({1'b0, div_rsp.rem[15:0]});
        if (lo_reg) begin
            wrapped = (r17 == 17'sd0) ? 17'(cfg.min_pos) : 17'(cfg.min_pos) + span - r17;
        end else begin
            wrapped = (r17 == 17'sd0) ? 17'(cfg.max_pos) : 17'(cfg.max_pos) + r17 - span;
        end
        q1s = num1_reg[27] ? -$signed({3'd0, div_rsp.quot[24:0]})
                           : $signed({3'd0, div_rsp.quot[24:0]});
    end

    always_comb begin
        state_next = state_reg;
        pay_next   = pay_reg;
        wcnt_next  = wcnt_reg;
        j_next     = j_reg;
        bus_next   = bus_reg;
        k_next     = k_reg;
        rec_next   = rec_reg;
        num1_next  = num1_reg;
        den_next   = den_reg;
        nr_next    = nr_reg;
        prod_next  = prod_reg;
        num2_next  = num2_reg;
        q2_next    = q2_reg;
        lo_next    = lo_reg;
        np_next    = np_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        mem_req    = '0;
        div_req    = '0;
        out_item   = '0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_item.kind) begin
                        k_next     = '0;
                        state_next = S_TRD;
                    end else if (fid_ok && (words != 3'd0)) begin
                        pay_next   = in_item.payload;
                        wcnt_next  = words;
                        j_next     = j_base;
                        bus_next   = in_item.bus;
                        state_next = S_FRD;
                    end
                end
            end
            S_FRD: begin
                if (j_ok) begin
                    mem_req.rd   = 1'b1;
                    mem_req.addr = j_addr;
                    state_next   = S_FWR;
                end else begin
                    pay_next  = {pay_reg[47:0], 16'd0};
                    wcnt_next = wcnt_reg - 3'd1;
                    j_next    = j_reg + 5'sd1;
                    if (wcnt_reg == 3'd1) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FWR: begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = j_addr;
                mem_req.wdata = mem_rdata;
                if (cfg.control_mode) begin
                    mem_req.wdata.rpm = clamp_rpm(28'(word), cfg.max_rpm);
                end else begin
                    mem_req.wdata.acc = word;
                end
                pay_next  = {pay_reg[47:0], 16'd0};
                wcnt_next = wcnt_reg - 3'd1;
                j_next    = j_reg + 5'sd1;
                state_next = (wcnt_reg == 3'd1) ? S_IDLE : S_FRD;
            end
            S_TRD: begin
                mem_req.rd   = 1'b1;
                mem_req.addr = k_reg;
                state_next   = S_TLAT;
            end
            S_TLAT: begin
                rec_next   = mem_rdata;
                state_next = S_TNUM1;
            end
            S_TNUM1: begin
                num1_next  = 28'(rec_reg.rpm) * 28'($signed({1'b0, hz_eff}))
                             + 28'(rec_reg.acc);
                den_next   = 17'(hz_eff) * 17'd120;
                state_next = S_D1S;
            end
            S_D1S: begin
                div_req.start    = 1'b1;
                div_req.dividend = cme_pkg::DVD_W'(num1_reg[27] ? -num1_reg : num1_reg);
                div_req.divisor  = cme_pkg::DVS_W'(hz_eff);
                state_next       = S_D1W;
            end
            S_D1W: begin
                if (div_rsp.done) begin
                    nr_next    = clamp_rpm(q1s, cfg.max_rpm);
                    state_next = S_TPROD;
                end
            end
            S_TPROD: begin
                prod_next  = 34'(rec_reg.pos) * 34'($signed({1'b0, den_reg}));
                state_next = S_TNUM2;
            end
            S_TNUM2: begin
                num2_next  = prod_reg + (34'(rsum) <<< 13) - 34'(rsum);
                state_next = S_D2S;
            end
            S_D2S: begin
                div_req.start    = 1'b1;
                div_req.dividend = cme_pkg::DVD_W'(num2_reg[33] ? -num2_reg : num2_reg);
                div_req.divisor  = den_reg;
                state_next       = S_D2W;
            end
            S_D2W: begin
                if (div_rsp.done) begin
                    q2_next = num2_reg[33] ? -$signed({1'b0, div_rsp.quot[25:0]})
                                           : $signed({1'b0, div_rsp.quot[25:0]});
                    state_next = S_WRAP;
                end
            end
            S_WRAP: begin
                // wrap range empty: pin to the lower bound
                if (span <= 17'sd0) begin
                    np_next    = cfg.min_pos;
                    state_next = S_TOUT;
                end else if (lo_gap > 28'sd0) begin
                    lo_next          = 1'b1;
                    div_req.start    = 1'b1;
                    div_req.dividend = cme_pkg::DVD_W'(lo_gap);
                    div_req.divisor  = cme_pkg::DVS_W'(span);
                    state_next       = S_D3W;
                end else if (hi_gap > 28'sd0) begin
                    lo_next          = 1'b0;
                    div_req.start    = 1'b1;
                    div_req.dividend = cme_pkg::DVD_W'(hi_gap);
                    div_req.divisor  = cme_pkg::DVS_W'(span);
                    state_next       = S_D3W;
                end else begin
                    np_next    = q2_reg[15:0];
                    state_next = S_TOUT;
                end
            end
            S_D3W: begin
                if (div_rsp.done) begin
                    np_next    = wrapped[15:0];
                    state_next = S_TOUT;
                end
            end
            S_TOUT: begin
                out_item.out_bus        = (k_reg >= cme_pkg::ADDR_W'(cme_pkg::BUS0_MOTORS));
                out_item.motor_id       = out_item.out_bus
                    ? cme_pkg::BUS1_FIRST_ID + 11'(k_reg) - 11'(cme_pkg::BUS0_MOTORS)
                    : cme_pkg::BUS0_FIRST_ID + 11'(k_reg);
                out_item.motor_position = np_reg;
                out_item.motor_rpm      = nr_reg;
                out_item.motor_acc      = rec_reg.acc;
                out_item.last           = (k_reg == cme_pkg::ADDR_W'(cme_pkg::NMOT - 1));
                if (out_free) begin
                    out_load      = 1'b1;
                    mem_req.wr    = 1'b1;
                    mem_req.addr  = k_reg;
                    mem_req.wdata = '{pos: np_reg, rpm: nr_reg, acc: rec_reg.acc};
                    k_next        = k_reg + 1'b1;
                    state_next    = out_item.last ? S_IDLE : S_TRD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        pay_reg  <= pay_next;
        wcnt_reg <= wcnt_next;
        j_reg    <= j_next;
        bus_reg  <= bus_next;
        k_reg    <= k_next;
        rec_reg  <= rec_next;
        num1_reg <= num1_next;
        den_reg  <= den_next;
        nr_reg   <= nr_next;
        prod_reg <= prod_next;
        num2_reg <= num2_next;
        q2_reg   <= q2_next;
        lo_reg   <= lo_next;
        np_reg   <= np_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_mem_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.rd && mem_req.wr))
        else $error("memory read and write in the same cycle");
    a_mem_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_req.rd || mem_req.wr) |-> (mem_req.addr < cme_pkg::ADDR_W'(cme_pkg::NMOT)))
        else $error("memory address out of range");
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> !div_rsp.busy)
        else $error("divider busy while idle");
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_D1W || state_reg == S_D2W || state_reg == S_D3W))
        else $error("divider result with nobody waiting");
    a_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

>>> hdl/can_motor_emulator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_motor_emulator_top
// Emulates nine CAN motors on two buses: control frames set acceleration or
// rpm, ticks integrate every motor and report one feedback transaction each.
// ----------------------------------------------------------------------------
//  channel  | ports                         | carries
//  s_       | s_valid s_ready s_payload     | control frame or tick
//  m_       | m_valid m_ready m_payload     | motor feedback, last on 9th
//  cfg_     | cfg_valid cfg_ready cfg_index | register write, cfg_data
//
// Control frame: read and write per word of a present motor, other words skipped.
// Tick: per motor, two or three 33-step divisions (three when the position
// wraps) on the one shared divider.
// Reset is synchronous; the motor memory reads as zero until written.
// A stalled m_ holds the sequencer in its output step; s_ready is low
// throughout a frame or tick.
// ----------------------------------------------------------------------------
module can_motor_emulator_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire cme_pkg::in_item_t                 s_payload,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output cme_pkg::out_item_t                     m_payload,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cme_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [15:0]                       cfg_data
);
    cme_pkg::cfg_t       cfg_reg;
    logic                m_valid_reg;
    cme_pkg::out_item_t  m_item_reg;
    logic                out_load;
    logic                out_free;
    cme_pkg::out_item_t  out_item;
    cme_pkg::mem_req_t   mem_req;
    cme_pkg::motor_rec_t mem_rdata;
    cme_pkg::div_req_t   div_req;
    cme_pkg::div_rsp_t   div_rsp;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.control_mode <= 1'b0;
            cfg_reg.update_hz    <= 10'd100;
            cfg_reg.max_rpm      <= 15'd1000;
            cfg_reg.max_pos      <= 16'sd8191;
            cfg_reg.min_pos      <= 16'sd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cme_pkg::REG_MODE:    cfg_reg.control_mode <= cfg_data[0];
                cme_pkg::REG_HZ:      cfg_reg.update_hz    <= cfg_data[9:0];
                cme_pkg::REG_MAX_RPM: cfg_reg.max_rpm      <= cfg_data[14:0];
                cme_pkg::REG_MAX_POS: cfg_reg.max_pos      <= cfg_data;
                cme_pkg::REG_MIN_POS: cfg_reg.min_pos      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg <= out_item;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_item_reg;

    cme_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_payload),
        .cfg       (cfg_reg),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_item  (out_item),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    cme_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rdata   (mem_rdata)
    );

    cme_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CAN motor emulator: drives control frames and
// ticks, predicts every motor's feedback and compares each transaction.
// ----------------------------------------------------------------------------
module testbench;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cme_pkg::in_item_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    cme_pkg::out_item_t m_payload;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [cme_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    can_motor_emulator_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the registers and motor stores
    logic        mode_q;
    logic [9:0]  hz_q;
    logic [14:0] rpm_lim_q;
    logic signed [15:0] pos_hi_q, pos_lo_q;
    longint rpm_m[cme_pkg::NMOT], pos_m[cme_pkg::NMOT], acc_m[cme_pkg::NMOT];

    cme_pkg::out_item_t feedback_q[$];
    int errors = 0;
    bit quiet = 1'b0;   // no-idle stretch

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < 9);
    endfunction

    function automatic longint clamp_speed(longint v);
        longint m = rpm_lim_q;
        if (v < -m) return -m;
        if (v > m) return m;
        return v;
    endfunction

    function automatic longint wrap_angle(longint q);
        longint d = longint'(pos_hi_q) - longint'(pos_lo_q);
        longint lo = pos_lo_q;
        longint hi = pos_hi_q;
        if (d <= 0) return lo;
        if (q < lo) q += ((lo - q + d - 1) / d) * d;
        else if (q > hi) q -= ((q - hi + d - 1) / d) * d;
        return q;
    endfunction

    task automatic predict_item(input cme_pkg::in_item_t it);
        longint base, first, cnt, offs, j, w, hz, old, nr, den, q;
        int unsigned words;
        cme_pkg::out_item_t fb;
        if (!it.kind) begin
            if (it.frame_id == cme_pkg::FID_LOW) base = 'h201;
            else if (it.frame_id == cme_pkg::FID_MID) base = 'h205;
            else if (it.frame_id == cme_pkg::FID_HIGH) base = 'h209;
            else return;
            words = ((it.length > 8) ? 8 : it.length) / 2;
            first = it.bus ? cme_pkg::BUS1_FIRST_ID : cme_pkg::BUS0_FIRST_ID;
            cnt = it.bus ? cme_pkg::BUS1_MOTORS : cme_pkg::BUS0_MOTORS;
            offs = it.bus ? cme_pkg::BUS0_MOTORS : 0;
            for (int i = 0; i < words; i++) begin
                w = longint'($signed(it.payload[63-16*i -: 16]));
                j = base + i - first;
                if (j >= 0 && j < cnt) begin
                    if (mode_q) rpm_m[offs+j] = clamp_speed(w);
                    else acc_m[offs+j] = w;
                end
            end
            return;
        end
        hz = (hz_q == 0) ? 1 : hz_q;
        for (int k = 0; k < cme_pkg::NMOT; k++) begin
            old = rpm_m[k];
            nr = clamp_speed((old * hz + acc_m[k]) / hz);
            den = 120 * hz;
            q = (pos_m[k] * den + (nr + old) * 8191) / den;
            rpm_m[k] = nr;
            pos_m[k] = wrap_angle(q);
            fb.out_bus = (k >= cme_pkg::BUS0_MOTORS);
            fb.motor_id = (k >= cme_pkg::BUS0_MOTORS)
                ? cme_pkg::BUS1_FIRST_ID + 11'(k - cme_pkg::BUS0_MOTORS)
                : cme_pkg::BUS0_FIRST_ID + 11'(k);
            fb.motor_position = 16'(pos_m[k]);
            fb.motor_rpm = 16'(rpm_m[k]);
            fb.motor_acc = 16'(acc_m[k]);
            fb.last = (k == cme_pkg::NMOT - 1);
            feedback_q.push_back(fb);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    // result channel: ready toggling and checking
    always @(posedge aclk) begin
        cme_pkg::out_item_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (feedback_q.size() == 0) begin
                    report_mismatch("unexpected feedback transaction", m_payload.motor_id, -1);
                end else begin
                    e = feedback_q.pop_front();
                    if (m_payload.out_bus !== e.out_bus)
                        report_mismatch("out_bus", m_payload.out_bus, e.out_bus);
                    if (m_payload.motor_id !== e.motor_id)
                        report_mismatch("motor_id", m_payload.motor_id, e.motor_id);
                    if (m_payload.motor_position !== e.motor_position)
                        report_mismatch("motor_position", m_payload.motor_position,
                                        e.motor_position);
                    if (m_payload.motor_rpm !== e.motor_rpm)
                        report_mismatch("motor_rpm", m_payload.motor_rpm, e.motor_rpm);
                    if (m_payload.motor_acc !== e.motor_acc)
                        report_mismatch("motor_acc", m_payload.motor_acc, e.motor_acc);
                    if (m_payload.last !== e.last)
                        report_mismatch("last", m_payload.last, e.last);
                end
            end
            m_ready <= !idle_now();
        end
    end

    // valid stays high after acceptance; drain() or an idle gap in the next call lowers it
    task automatic send_item(input cme_pkg::in_item_t it);
        if (idle_now()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (idle_now()) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (feedback_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [cme_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            cme_pkg::REG_MODE:    mode_q = val[0];
            cme_pkg::REG_HZ:      hz_q = val[9:0];
            cme_pkg::REG_MAX_RPM: rpm_lim_q = val[14:0];
            cme_pkg::REG_MAX_POS: pos_hi_q = val;
            cme_pkg::REG_MIN_POS: pos_lo_q = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic m, input logic [9:0] hz, input logic [14:0] lim,
                             input logic [15:0] hi, input logic [15:0] lo);
        drain();
        write_reg(cme_pkg::REG_MODE, 16'(m));
        write_reg(cme_pkg::REG_HZ, 16'(hz));
        write_reg(cme_pkg::REG_MAX_RPM, 16'(lim));
        write_reg(cme_pkg::REG_MAX_POS, hi);
        write_reg(cme_pkg::REG_MIN_POS, lo);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic cme_pkg::in_item_t make_frame(input logic b, input logic [10:0] id,
                                                     input logic [3:0] len,
                                                     input logic [63:0] d);
        cme_pkg::in_item_t it;
        it.kind = 1'b0;
        it.bus = b;
        it.frame_id = id;
        it.length = len;
        it.payload = d;
        return it;
    endfunction

    function automatic cme_pkg::in_item_t make_tick();
        cme_pkg::in_item_t it;
        it.kind = 1'b1;
        it.bus = 1'($urandom);
        it.frame_id = 11'($urandom);
        it.length = 4'($urandom);
        it.payload = {$urandom, $urandom};
        return it;
    endfunction

    function automatic logic [10:0] pick_id();
        case ($urandom_range(9))
            0: return 11'($urandom);
            1, 2, 3: return cme_pkg::FID_LOW;
            4, 5, 6: return cme_pkg::FID_MID;
            default: return cme_pkg::FID_HIGH;
        endcase
    endfunction

    task automatic test_directed();
        send_item(make_tick());
        send_item(make_frame(0, cme_pkg::FID_LOW, 4'd8, 64'h7FFF_8000_0001_FFFF));
        send_item(make_frame(0, cme_pkg::FID_MID, 4'd15, 64'h1234_8000_7FFF_0005));
        send_item(make_frame(1, cme_pkg::FID_MID, 4'd8, 64'h0100_FF00_2000_0003));
        send_item(make_frame(1, cme_pkg::FID_HIGH, 4'd6, 64'h4000_4000_4000_4000));
        send_item(make_frame(0, 11'h123, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
        send_item(make_frame(1, cme_pkg::FID_LOW, 4'd3, 64'h0BAD_0000_0000_0000));
        send_item(make_frame(0, cme_pkg::FID_HIGH, 4'd0, 64'hFFFF_0000_0000_0000));
        repeat (3) send_item(make_tick());
        configure(1, 10'd1, 15'h7FFF, 16'h7FFF, 16'h8000);
        send_item(make_frame(0, cme_pkg::FID_LOW, 4'd8, 64'h7FFF_8000_8001_0001));
        send_item(make_frame(0, cme_pkg::FID_MID, 4'd4, 64'h7FFF_8000_0000_0000));
        send_item(make_frame(1, cme_pkg::FID_MID, 4'd8, 64'h7FFF_8000_7FFF_0000));
        repeat (3) send_item(make_tick());
        configure(0, 10'd0, 15'd0, 16'd5, 16'd5);
        send_item(make_frame(0, cme_pkg::FID_LOW, 4'd2, 64'h7FFF_0000_0000_0000));
        repeat (2) send_item(make_tick());
        configure(1, 10'd1000, 15'd300, 16'h8000, 16'h7FFF);
        send_item(make_tick());
        configure(0, 10'd3, 15'd5000, 16'd100, 16'hFF9C);
        send_item(make_frame(0, cme_pkg::FID_LOW, 4'd8, 64'h8000_7FFF_8000_7FFF));
        repeat (2) send_item(make_tick());
    endtask

    task automatic test_random(input int n);
        logic [15:0] a, b;
        for (int i = 0; i < n; i++) begin
            if (i % 80 == 0) begin
                a = 16'($urandom);
                b = 16'($urandom);
                if ($urandom_range(3) != 0) begin
                    a = 16'($urandom_range(20000));
                    b = -16'($urandom_range(20000));
                end
                configure(1'($urandom), ($urandom_range(3) == 0) ? 10'($urandom)
                          : 10'($urandom_range(1, 200)), 15'($urandom), a, b);
            end
            quiet = (i >= 150 && i < 200);
            if ($urandom_range(2) == 0) send_item(make_tick());
            else send_item(make_frame(1'($urandom), pick_id(),
                                      4'($urandom_range(15)), {$urandom, $urandom}));
        end
        quiet = 1'b0;
    endtask

    initial begin
        mode_q = 0; hz_q = 100; rpm_lim_q = 1000; pos_hi_q = 8191; pos_lo_q = 0;
        for (int k = 0; k < cme_pkg::NMOT; k++) begin
            rpm_m[k] = 0; pos_m[k] = 0; acc_m[k] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(300);
        drain();
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
